// ----- rtl/tnnt_pkg.sv -----
`default_nettype none

package tnnt_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 12;

	localparam int ADDR_BITS = $clog2(MAX_POINTS);
	localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
	localparam int IDX_BITS  = 6;

	// floor(sqrt(dx^2 + dy^2)) needs one more bit than a coordinate
	localparam int ROOT_BITS = COORD_BITS + 1;
	localparam int SUM_BITS  = 2 * COORD_BITS + 1;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int REM_BITS  = ROOT_BITS + 2;

	localparam int IN_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_RAW  = 3 * IDX_BITS + 6 * COORD_BITS;
	localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [ROOT_BITS-1:0]  root_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} point_t;

endpackage

`default_nettype wire

// ----- rtl/two_nearest_neighbor_triangles_unit.sv -----
// Points arrive one per request on the slave stream (x, y, tlast marks the last point of a
// set) and are taken one per cycle into a 64-entry point memory; points beyond 64 are
// dropped. The request with tlast starts a brute-force search: for each stored point, in
// index order, the block streams every other point out of the memory, one pair per cycle,
// through a pipelined distance and square-root unit, and keeps the nearest and the
// second-nearest (floor of the Euclidean distance, earlier index wins a tie). One result
// per point goes out on the master stream, tlast on the result of the last point, tuser
// high when both neighbors exist. The search for each point of a set of n points is one read of
// the center, n reads of candidates through the single read port of the point memory, a
// drain of the 17-stage distance pipeline and a handoff of the result to the output
// register; a stalled output register adds its wait. No new point is taken until the set's
// last result is in the output register.
`default_nettype none

module two_nearest_neighbor_triangles_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [tnnt_pkg::IN_BITS-1:0]  s_axis_tdata,  // pos_x, pos_y
	input  wire logic                          s_axis_tlast,  // final_point

	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [tnnt_pkg::OUT_BITS-1:0]      m_axis_tdata,  // center_index, near_index,
	                                                          // second_index, near_x, near_y,
	                                                          // second_x, second_y,
	                                                          // center_x, center_y
	output logic                               m_axis_tuser,  // found
	output logic                               m_axis_tlast   // last_of_run
);

	localparam int RB = tnnt_pkg::ROOT_BITS;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_CRD   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [tnnt_pkg::CNT_BITS-1:0] cnt_q;
	tnnt_pkg::addr_t i_q;
	tnnt_pkg::addr_t j_q;

	// point memory
	tnnt_pkg::point_t point_mem [tnnt_pkg::MAX_POINTS];
	tnnt_pkg::point_t rd_q;
	tnnt_pkg::addr_t  rd_addr;
	logic             wr_en;
	tnnt_pkg::point_t wr_pt;

	// center point
	logic              cen_s1;
	tnnt_pkg::point_t  cen_q;

	// distance pipeline
	logic              v_s1, v_s2, v_s3;
	tnnt_pkg::addr_t   j_s1, j_s2, j_s3;
	tnnt_pkg::point_t  pt_s2, pt_s3;
	tnnt_pkg::coord_t  dx_s2, dy_s2;
	logic [2*tnnt_pkg::COORD_BITS-1:0] dx2_s3, dy2_s3;

	// square root stages, entry 0 holds the radicand
	logic                            sq_v   [RB+1];
	logic [tnnt_pkg::RAD_BITS-1:0]   sq_val [RB+1];
	logic [tnnt_pkg::REM_BITS-1:0]   sq_rem [RB+1];
	tnnt_pkg::root_t                 sq_root[RB+1];
	tnnt_pkg::addr_t                 sq_j   [RB+1];
	tnnt_pkg::point_t                sq_pt  [RB+1];
	logic [tnnt_pkg::REM_BITS+1:0]   rem_w  [RB];
	logic [tnnt_pkg::REM_BITS+1:0]   trial_w[RB];
	logic                            ge_w   [RB];

	// running best two
	logic              v1_q, v2_q;
	tnnt_pkg::addr_t   b1_q, b2_q;
	tnnt_pkg::root_t   d1_q, d2_q;
	tnnt_pkg::point_t  p1_q, p2_q;

	// output register
	logic                          out_valid_q;
	logic [tnnt_pkg::OUT_BITS-1:0] out_data_q;
	logic                          out_found_q;
	logic                          out_last_q;

	logic in_fire, busy_w, scan_last, emit_last, out_load, found_w;
	logic sq_any;
	logic [tnnt_pkg::SUM_BITS-1:0] sum_w;
	tnnt_pkg::root_t d_w;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign wr_en         = in_fire && (cnt_q < tnnt_pkg::CNT_BITS'(tnnt_pkg::MAX_POINTS));
	assign wr_pt.x       = s_axis_tdata[tnnt_pkg::COORD_BITS-1:0];
	assign wr_pt.y       = s_axis_tdata[2*tnnt_pkg::COORD_BITS-1:tnnt_pkg::COORD_BITS];

	assign scan_last = (tnnt_pkg::CNT_BITS'(j_q) + 1'b1) == cnt_q;
	assign emit_last = (tnnt_pkg::CNT_BITS'(i_q) + 1'b1) == cnt_q;
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	assign found_w   = v1_q && v2_q;

	always_comb begin
		sq_any = 1'b0;
		for (int s = 0; s <= RB; s++) begin
			sq_any = sq_any | sq_v[s];
		end
	end
	assign busy_w = v_s1 || v_s2 || v_s3 || sq_any;

	always_comb begin
		unique case (state_q)
			ST_CRD:  rd_addr = i_q;
			default: rd_addr = j_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			point_mem[cnt_q[tnnt_pkg::ADDR_BITS-1:0]] <= wr_pt;
		end
		rd_q <= point_mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (wr_en) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (in_fire && s_axis_tlast) begin
						i_q     <= '0;
						state_q <= ST_CRD;
					end
				end
				ST_CRD: begin
					j_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!busy_w) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (emit_last) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_CRD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_s1 <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			for (int s = 0; s <= RB; s++) begin
				sq_v[s] <= 1'b0;
			end
		end else begin
			cen_s1  <= (state_q == ST_CRD);
			v_s1    <= (state_q == ST_SCAN) && (j_q != i_q);
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			sq_v[0] <= v_s3;
			for (int s = 0; s < RB; s++) begin
				sq_v[s+1] <= sq_v[s];
			end
		end
	end

	assign sum_w = tnnt_pkg::SUM_BITS'(dx2_s3) + tnnt_pkg::SUM_BITS'(dy2_s3);

	// one result bit per stage: bring down two radicand bits, try subtracting 4q+1
	always_comb begin
		for (int s = 0; s < RB; s++) begin
			rem_w[s]   = {sq_rem[s], sq_val[s][2*(RB-1-s) +: 2]};
			trial_w[s] = (tnnt_pkg::REM_BITS+2)'({sq_root[s], 2'b01});
			ge_w[s]    = rem_w[s] >= trial_w[s];
		end
	end

	always_ff @(posedge clk) begin
		if (cen_s1) begin
			cen_q <= rd_q;
		end
		j_s1  <= j_q;
		j_s2  <= j_s1;
		pt_s2 <= rd_q;
		dx_s2 <= (rd_q.x > cen_q.x) ? rd_q.x - cen_q.x : cen_q.x - rd_q.x;
		dy_s2 <= (rd_q.y > cen_q.y) ? rd_q.y - cen_q.y : cen_q.y - rd_q.y;
		j_s3   <= j_s2;
		pt_s3  <= pt_s2;
		dx2_s3 <= dx_s2 * dx_s2;
		dy2_s3 <= dy_s2 * dy_s2;
		sq_val[0]  <= tnnt_pkg::RAD_BITS'(sum_w);
		sq_rem[0]  <= '0;
		sq_root[0] <= '0;
		sq_j[0]    <= j_s3;
		sq_pt[0]   <= pt_s3;
		for (int s = 0; s < RB; s++) begin
			sq_rem[s+1]  <= ge_w[s] ? tnnt_pkg::REM_BITS'(rem_w[s] - trial_w[s])
			                        : tnnt_pkg::REM_BITS'(rem_w[s]);
			sq_root[s+1] <= {sq_root[s][RB-2:0], ge_w[s]};
			sq_val[s+1]  <= sq_val[s];
			sq_j[s+1]    <= sq_j[s];
			sq_pt[s+1]   <= sq_pt[s];
		end
	end

	assign d_w = sq_root[RB];

	// best-two update; a strictly closer candidate pushes the old best down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else if (state_q == ST_CRD) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else if (sq_v[RB]) begin
			if (!v1_q || d_w < d1_q) begin
				v1_q <= 1'b1;
				v2_q <= v1_q;
			end else if (!v2_q || d_w < d2_q) begin
				v2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sq_v[RB]) begin
			priority if (!v1_q || d_w < d1_q) begin
				b2_q <= b1_q;
				d2_q <= d1_q;
				p2_q <= p1_q;
				b1_q <= sq_j[RB];
				d1_q <= d_w;
				p1_q <= sq_pt[RB];
			end else if (!v2_q || d_w < d2_q) begin
				b2_q <= sq_j[RB];
				d2_q <= d_w;
				p2_q <= sq_pt[RB];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= found_w;
			out_last_q  <= emit_last;
			out_data_q  <= tnnt_pkg::OUT_BITS'({
				cen_q.y,
				cen_q.x,
				found_w ? p2_q.y : '0,
				found_w ? p2_q.x : '0,
				found_w ? p1_q.y : '0,
				found_w ? p1_q.x : '0,
				found_w ? tnnt_pkg::IDX_BITS'(b2_q) : '0,
				found_w ? tnnt_pkg::IDX_BITS'(b1_q) : '0,
				tnnt_pkg::IDX_BITS'(i_q)
			});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tlast  = out_last_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !busy_w)
		else $error("point request taken while search pipeline busy");

	a_best_order: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q |-> (v1_q && d1_q <= d2_q))
		else $error("second neighbor closer than nearest");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tnnt_pkg::CNT_BITS'(tnnt_pkg::MAX_POINTS))
		else $error("point count beyond memory depth");

	a_found_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && found_w) |-> (b1_q != i_q && b2_q != i_q && b1_q != b2_q))
		else $error("neighbor index repeats center or other neighbor");

	a_emit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !busy_w)
		else $error("result emitted while pipeline still holds candidates");

endmodule

`default_nettype wire
